@@ rtl/adamw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adamw_pkg
// Shared widths, reset values, register codes and channel word types.
// ----------------------------------------------------------------------------
package adamw_pkg;

    localparam int unsigned NumParamsDefault = 4096;
    localparam int IdxW     = 12;
    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 24;

    localparam logic [15:0] Beta1Reset = 16'd58982;
    localparam logic [15:0] Beta2Reset = 16'd65470;
    localparam logic [23:0] LrReset    = 24'd16777;
    localparam logic [23:0] WdReset    = 24'd167772;
    localparam logic [31:0] OneQ131    = 32'h8000_0000;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_BETA1 = 4'd0,
        CFG_BETA2 = 4'd1,
        CFG_LR    = 4'd2,
        CFG_WD    = 4'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [IdxW-1:0]    param_index;
        logic signed [31:0] gradient;
        logic signed [31:0] weight;
        logic               new_step;
    } t_in_item;

    typedef struct packed {
        logic [IdxW-1:0]    out_index;
        logic signed [31:0] update;
        logic signed [31:0] new_weight;
    } t_out_item;

    // item at the moment update stage
    typedef struct packed {
        logic               valid;
        logic [IdxW-1:0]    index;
        logic signed [31:0] gradient;
        logic [31:0]        grad_sq;
    } t_mom_in;

endpackage
`default_nettype wire

@@ rtl/adamw_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adamw_stream_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface adamw_stream_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/adamw_moment_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adamw_moment_unit
// First and second moment stores with read-modify-write, forwarding of the
// last write and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module adamw_moment_unit #(
    parameter int unsigned NUM_PARAMS = adamw_pkg::NumParamsDefault
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic [adamw_pkg::IdxW-1:0]  i_rd_index,
    input  wire adamw_pkg::t_mom_in          i_item,
    input  wire logic [15:0]                 i_beta1,
    input  wire logic [15:0]                 i_beta2,
    output logic signed [31:0]               o_m,
    output logic [31:0]                      o_v,
    output logic                             o_busy
);
    localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

    logic signed [31:0] r_mem_m [NUM_PARAMS];
    logic [31:0]        r_mem_v [NUM_PARAMS];
    logic signed [31:0] r_rd_m;
    logic [31:0]        r_rd_v;

    logic                       r_wb_valid;
    logic [adamw_pkg::IdxW-1:0] r_wb_index;
    logic signed [31:0]         r_wb_m;
    logic [31:0]                r_wb_v;

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic signed [31:0] r_m;
    logic [31:0]        r_v;

    logic               in_range;
    logic               fwd;
    logic               upd_we;
    logic               we;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] m_old;
    logic [31:0]        v_old;
    logic signed [17:0] b1s;
    logic signed [17:0] c1s;
    logic signed [49:0] pm1;
    logic signed [49:0] pm2;
    logic signed [49:0] acc_m;
    logic signed [33:0] m_sh;
    logic signed [31:0] m_new;
    logic [16:0]        c2;
    logic [47:0]        pv1;
    logic [47:0]        pv2;
    logic [47:0]        acc_v;
    logic [31:0]        v_new;
    logic [31:0]        wr_m;
    logic [31:0]        wr_v;

    always_comb begin
        in_range = 32'(i_item.index) < NUM_PARAMS;
        fwd      = r_wb_valid && (r_wb_index == i_item.index);
        if (!in_range) begin
            m_old = '0;
            v_old = '0;
        end else if (fwd) begin
            m_old = r_wb_m;
            v_old = r_wb_v;
        end else begin
            m_old = r_rd_m;
            v_old = r_rd_v;
        end

        // floor of the weighted sum over 2^16
        b1s   = $signed({2'b00, i_beta1});
        c1s   = 18'sd65536 - b1s;
        pm1   = b1s * m_old;
        pm2   = c1s * i_item.gradient;
        acc_m = pm1 + pm2;
        m_sh  = acc_m[49:16];
        if (m_sh > 34'sd2147483647) begin
            m_new = 32'sh7FFF_FFFF;
        end else if (m_sh < -34'sd2147483648) begin
            m_new = 32'sh8000_0000;
        end else begin
            m_new = m_sh[31:0];
        end

        // sum stays below 2^48, so no saturation needed
        c2    = 17'd65536 - 17'(i_beta2);
        pv1   = 48'(i_beta2) * 48'(v_old);
        pv2   = 48'(c2) * 48'(i_item.grad_sq);
        acc_v = pv1 + pv2;
        v_new = acc_v[47:16];

        upd_we  = i_en && i_item.valid && in_range;
        we      = r_clr_busy || upd_we;
        rd_addr = AW'(32'(i_rd_index));
        wr_addr = r_clr_busy ? r_clr_addr : AW'(32'(i_item.index));
        wr_m    = r_clr_busy ? '0 : m_new;
        wr_v    = r_clr_busy ? '0 : v_new;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem_m[wr_addr] <= wr_m;
            r_mem_v[wr_addr] <= wr_v;
        end
        if (i_en) begin
            r_rd_m <= r_mem_m[rd_addr];
            r_rd_v <= r_mem_v[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_wb_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                if (32'(r_clr_addr) == NUM_PARAMS - 1) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
            end
            if (upd_we) begin
                r_wb_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_we) begin
            r_wb_index <= i_item.index;
            r_wb_m     <= m_new;
            r_wb_v     <= v_new;
        end
        if (i_en) begin
            r_m <= m_new;
            r_v <= v_new;
        end
    end

    assign o_m    = r_m;
    assign o_v    = r_v;
    assign o_busy = r_clr_busy;

endmodule
`default_nettype wire

@@ rtl/adamw_div_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adamw_div_pipe
// Restoring divider, one quotient bit per pipeline stage, with side word.
// ----------------------------------------------------------------------------
module adamw_div_pipe #(
    parameter int QW = 32,
    parameter int RW = 32,
    parameter int PW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [RW-1:0] i_rem,
    input  wire logic [RW-1:0] i_den,
    input  wire logic [QW-1:0] i_tail,
    input  wire logic [PW-1:0] i_pay,
    output logic               o_valid,
    output logic [QW-1:0]      o_quot,
    output logic [PW-1:0]      o_pay
);
    logic          r_valid [QW];
    logic [RW-1:0] r_rem   [QW];
    logic [RW-1:0] r_den   [QW];
    logic [QW-1:0] r_quot  [QW];
    logic [QW-1:0] r_tail  [QW];
    logic [PW-1:0] r_pay   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic          p_valid;
        logic [RW-1:0] p_rem;
        logic [RW-1:0] p_den;
        logic [QW-1:0] p_quot;
        logic [QW-1:0] p_tail;
        logic [PW-1:0] p_pay;
        logic [RW:0]   sh;
        logic          take;

        if (k == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_rem   = i_rem;
            assign p_den   = i_den;
            assign p_quot  = '0;
            assign p_tail  = i_tail;
            assign p_pay   = i_pay;
        end else begin : g_next
            assign p_valid = r_valid[k-1];
            assign p_rem   = r_rem[k-1];
            assign p_den   = r_den[k-1];
            assign p_quot  = r_quot[k-1];
            assign p_tail  = r_tail[k-1];
            assign p_pay   = r_pay[k-1];
        end

        // remainder stays below the divisor, so sh fits one extra bit
        assign sh   = {p_rem, p_tail[QW-1]};
        assign take = sh >= {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= take ? RW'(sh - {1'b0, p_den}) : RW'(sh);
                r_den[k]  <= p_den;
                r_quot[k] <= {p_quot[QW-2:0], take};
                r_tail[k] <= {p_tail[QW-2:0], 1'b0};
                r_pay[k]  <= p_pay;
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quot  = r_quot[QW-1];
    assign o_pay   = r_pay[QW-1];

endmodule
`default_nettype wire

@@ rtl/adamw_sqrt_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adamw_sqrt_pipe
// Integer square root, one root bit per pipeline stage, with side word.
// ----------------------------------------------------------------------------
module adamw_sqrt_pipe #(
    parameter int N  = 28,
    parameter int PW = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [2*N-1:0]  i_rad,
    input  wire logic [PW-1:0]   i_pay,
    output logic                 o_valid,
    output logic [N-1:0]         o_root,
    output logic [PW-1:0]        o_pay
);
    localparam int RADW = 2 * N;
    localparam int REMW = N + 2;

    logic            r_valid [N];
    logic [REMW-1:0] r_rem   [N];
    logic [N-1:0]    r_root  [N];
    logic [RADW-1:0] r_rad   [N];
    logic [PW-1:0]   r_pay   [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic            p_valid;
        logic [REMW-1:0] p_rem;
        logic [N-1:0]    p_root;
        logic [RADW-1:0] p_rad;
        logic [PW-1:0]   p_pay;
        logic [REMW-1:0] sh;
        logic [REMW-1:0] trial;
        logic            take;

        if (k == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_rem   = '0;
            assign p_root  = '0;
            assign p_rad   = i_rad;
            assign p_pay   = i_pay;
        end else begin : g_next
            assign p_valid = r_valid[k-1];
            assign p_rem   = r_rem[k-1];
            assign p_root  = r_root[k-1];
            assign p_rad   = r_rad[k-1];
            assign p_pay   = r_pay[k-1];
        end

        // bring down the next two radicand bits, try 4*root + 1
        assign sh    = {p_rem[REMW-3:0], p_rad[RADW-1 -: 2]};
        assign trial = {p_root, 2'b01};
        assign take  = sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= take ? (sh - trial) : sh;
                r_root[k] <= {p_root[N-2:0], take};
                r_rad[k]  <= {p_rad[RADW-3:0], 2'b00};
                r_pay[k]  <= p_pay;
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_root  = r_root[N-1];
    assign o_pay   = r_pay[N-1];

endmodule
`default_nettype wire

@@ rtl/adamw_parameter_update_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adamw_parameter_update_core
// AdamW update of one parameter per word: moments, bias correction, step.
// ----------------------------------------------------------------------------
// Takes one word per clock while the output is not stalled and returns one
// result word per input word, in order. The pipeline stalls as a whole
// while a result waits at the output register.
// Depth comes from the two 32-stage bias-correction dividers (in parallel),
// the 28-stage square root and the 34-stage step divider. The moments sit
// in two single-port-write memories whose read is registered alongside
// stage a; a write to the index read in the same cycle is forwarded. After
// reset a clearing pass over all NUM_PARAMS entries zeroes both memories,
// and no word is accepted until it ends; configuration writes are taken at
// any time but belong in idle periods.
module adamw_parameter_update_core #(
    parameter int unsigned NUM_PARAMS = adamw_pkg::NumParamsDefault
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    adamw_stream_if.sink                         i_in,
    adamw_stream_if.source                       o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [adamw_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [adamw_pkg::CfgDataW-1:0]  i_cfg_data
);
    localparam logic [31:0] One = adamw_pkg::OneQ131;

    typedef struct packed {
        logic [adamw_pkg::IdxW-1:0] idx;
        logic signed [31:0]         w;
        logic signed [31:0]         m;
        logic                       m_neg;
        logic                       m_ovf;
        logic                       m_byp;
    } t_mdiv_side;

    typedef struct packed {
        logic [31:0] v;
        logic        v_ovf;
        logic        v_byp;
    } t_vdiv_side;

    typedef struct packed {
        logic [adamw_pkg::IdxW-1:0] idx;
        logic signed [31:0]         w;
        logic signed [31:0]         m_hat;
    } t_sq_side;

    typedef struct packed {
        logic [adamw_pkg::IdxW-1:0] idx;
        logic signed [31:0]         w;
        logic                       a_neg;
        logic                       a_ovf;
        logic signed [31:0]         decay;
    } t_adam_side;

    // configuration and beta powers
    logic [15:0] r_beta1;
    logic [15:0] r_beta2;
    logic [23:0] r_lr;
    logic [23:0] r_wd;
    logic [31:0] r_pow1;
    logic [31:0] r_pow2;

    logic        en;
    logic        accept;
    logic        clr_busy;
    logic [47:0] pow1_prod;
    logic [47:0] pow2_prod;

    assign en          = !o_out.valid || o_out.ready;
    assign i_in.ready  = en && !clr_busy;
    assign accept      = i_in.valid && i_in.ready;
    assign pow1_prod   = 48'(r_pow1) * 48'(r_beta1);
    assign pow2_prod   = 48'(r_pow2) * 48'(r_beta2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta1 <= adamw_pkg::Beta1Reset;
            r_beta2 <= adamw_pkg::Beta2Reset;
            r_lr    <= adamw_pkg::LrReset;
            r_wd    <= adamw_pkg::WdReset;
            r_pow1  <= One;
            r_pow2  <= One;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    adamw_pkg::CFG_BETA1: begin
                        r_beta1 <= i_cfg_data[15:0];
                    end
                    adamw_pkg::CFG_BETA2: begin
                        r_beta2 <= i_cfg_data[15:0];
                    end
                    adamw_pkg::CFG_LR: begin
                        r_lr <= i_cfg_data;
                    end
                    adamw_pkg::CFG_WD: begin
                        r_wd <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (accept && i_in.data.new_step) begin
                r_pow1 <= pow1_prod[47:16];
                r_pow2 <= pow2_prod[47:16];
            end
        end
    end

    // stage a: accepted word, squared gradient
    logic                       r_a_valid;
    logic [adamw_pkg::IdxW-1:0] r_a_idx;
    logic signed [31:0]         r_a_g;
    logic signed [31:0]         r_a_w;
    logic [31:0]                r_a_g2;

    logic [31:0] g_mag;
    logic [63:0] g_sq;
    logic [31:0] g2;

    always_comb begin
        g_mag = i_in.data.gradient[31] ? (~i_in.data.gradient + 32'd1)
                                       : i_in.data.gradient;
        g_sq  = 64'(g_mag) * 64'(g_mag);
        g2    = (|g_sq[63:56]) ? 32'hFFFF_FFFF : g_sq[55:24];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_idx <= i_in.data.param_index;
            r_a_g   <= i_in.data.gradient;
            r_a_w   <= i_in.data.weight;
            r_a_g2  <= g2;
        end
    end

    adamw_pkg::t_mom_in mom_in;
    logic signed [31:0] mom_m;
    logic [31:0]        mom_v;

    assign mom_in = '{valid: r_a_valid, index: r_a_idx, gradient: r_a_g, grad_sq: r_a_g2};

    adamw_moment_unit #(
        .NUM_PARAMS (NUM_PARAMS)
    ) u_moment (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_rd_index (i_in.data.param_index),
        .i_item     (mom_in),
        .i_beta1    (r_beta1),
        .i_beta2    (r_beta2),
        .o_m        (mom_m),
        .o_v        (mom_v),
        .o_busy     (clr_busy)
    );

    // stage b: fresh moments, bias-correction denominators
    logic                       r_b_valid;
    logic [adamw_pkg::IdxW-1:0] r_b_idx;
    logic signed [31:0]         r_b_w;
    logic [31:0]                r_b_d1;
    logic [31:0]                r_b_d2;

    logic [31:0] d1;
    logic [31:0] d2;

    assign d1 = One - ((r_pow1 > One) ? One : r_pow1);
    assign d2 = One - ((r_pow2 > One) ? One : r_pow2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_idx <= r_a_idx;
            r_b_w   <= r_a_w;
            r_b_d1  <= d1;
            r_b_d2  <= d2;
        end
    end

    logic [31:0] m_mag;
    logic        m_byp;
    logic        m_ovf;
    logic [31:0] rem1;
    logic        v_byp;
    logic        v_ovf;
    logic [31:0] rem2;
    t_mdiv_side  mside_in;
    t_vdiv_side  vside_in;

    // quotient reaches 2^31 (first) or 2^32 (second) exactly when these hold
    always_comb begin
        m_mag = mom_m[31] ? (~mom_m + 32'd1) : mom_m;
        m_byp = (r_b_d1 == '0);
        m_ovf = !m_byp && (m_mag >= r_b_d1);
        rem1  = m_ovf ? '0 : {1'b0, m_mag[31:1]};
        v_byp = (r_b_d2 == '0);
        v_ovf = !v_byp && ({1'b0, mom_v} >= {r_b_d2, 1'b0});
        rem2  = v_ovf ? '0 : {1'b0, mom_v[31:1]};
        mside_in = '{idx: r_b_idx, w: r_b_w, m: mom_m, m_neg: mom_m[31],
                     m_ovf: m_ovf, m_byp: m_byp};
        vside_in = '{v: mom_v, v_ovf: v_ovf, v_byp: v_byp};
    end

    logic                          mdiv_valid;
    logic [31:0]                   mdiv_q;
    logic [$bits(t_mdiv_side)-1:0] mdiv_pay;
    logic                          vdiv_valid;
    logic [31:0]                   vdiv_q;
    logic [$bits(t_vdiv_side)-1:0] vdiv_pay;

    adamw_div_pipe #(
        .QW (32),
        .RW (32),
        .PW ($bits(t_mdiv_side))
    ) u_mdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_valid),
        .i_rem   (rem1),
        .i_den   (r_b_d1),
        .i_tail  ({m_mag[0], 31'b0}),
        .i_pay   (mside_in),
        .o_valid (mdiv_valid),
        .o_quot  (mdiv_q),
        .o_pay   (mdiv_pay)
    );

    adamw_div_pipe #(
        .QW (32),
        .RW (32),
        .PW ($bits(t_vdiv_side))
    ) u_vdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_valid),
        .i_rem   (rem2),
        .i_den   (r_b_d2),
        .i_tail  ({mom_v[0], 31'b0}),
        .i_pay   (vside_in),
        .o_valid (vdiv_valid),
        .o_quot  (vdiv_q),
        .o_pay   (vdiv_pay)
    );

    t_mdiv_side         mside;
    t_vdiv_side         vside;
    logic signed [31:0] m_hat;
    logic [31:0]        v_hat;
    t_sq_side           sq_in;

    always_comb begin
        mside = t_mdiv_side'(mdiv_pay);
        vside = t_vdiv_side'(vdiv_pay);
        if (mside.m_byp) begin
            m_hat = mside.m;
        end else if (mside.m_ovf) begin
            m_hat = mside.m_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            m_hat = mside.m_neg ? (~mdiv_q + 32'd1) : mdiv_q;
        end
        if (vside.v_byp) begin
            v_hat = vside.v;
        end else if (vside.v_ovf) begin
            v_hat = 32'hFFFF_FFFF;
        end else begin
            v_hat = vdiv_q;
        end
        sq_in = '{idx: mside.idx, w: mside.w, m_hat: m_hat};
    end

    logic                        sq_valid;
    logic [27:0]                 sq_root;
    logic [$bits(t_sq_side)-1:0] sq_pay;

    adamw_sqrt_pipe #(
        .N  (28),
        .PW ($bits(t_sq_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mdiv_valid),
        .i_rad   ({v_hat, 24'b0}),
        .i_pay   (sq_in),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_pay   (sq_pay)
    );

    // stage d: denominator and the two products
    logic                       r_d_valid;
    logic [adamw_pkg::IdxW-1:0] r_d_idx;
    logic signed [31:0]         r_d_w;
    logic [28:0]                r_d_den;
    logic signed [56:0]         r_d_pa;
    logic signed [56:0]         r_d_pw;

    t_sq_side           sq_side;
    logic signed [56:0] prod_a;
    logic signed [56:0] prod_w;

    always_comb begin
        sq_side = t_sq_side'(sq_pay);
        prod_a  = $signed({1'b0, r_lr}) * sq_side.m_hat;
        prod_w  = $signed({1'b0, r_wd}) * sq_side.w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_idx <= sq_side.idx;
            r_d_w   <= sq_side.w;
            r_d_den <= 29'(sq_root) + 29'd1;
            r_d_pa  <= prod_a;
            r_d_pw  <= prod_w;
        end
    end

    logic               a_neg;
    logic signed [56:0] a_negv;
    logic [55:0]        a_mag;
    logic               a_ovf;
    logic [28:0]        rem3;
    logic               w_neg;
    logic signed [56:0] w_negv;
    logic [55:0]        w_mag;
    logic [31:0]        dmag;
    logic signed [31:0] decay;
    t_adam_side         aside_in;

    // step quotient at or above 2^34 saturates the update regardless
    always_comb begin
        a_neg  = r_d_pa[56];
        a_negv = -r_d_pa;
        a_mag  = a_neg ? a_negv[55:0] : r_d_pa[55:0];
        a_ovf  = {7'b0, a_mag[55:34]} >= r_d_den;
        rem3   = a_ovf ? '0 : {7'b0, a_mag[55:34]};
        w_neg  = r_d_pw[56];
        w_negv = -r_d_pw;
        w_mag  = w_neg ? w_negv[55:0] : r_d_pw[55:0];
        dmag   = w_mag[55:24];
        decay  = w_neg ? (~dmag + 32'd1) : dmag;
        aside_in = '{idx: r_d_idx, w: r_d_w, a_neg: a_neg, a_ovf: a_ovf, decay: decay};
    end

    logic                          adiv_valid;
    logic [33:0]                   adiv_q;
    logic [$bits(t_adam_side)-1:0] adiv_pay;

    adamw_div_pipe #(
        .QW (34),
        .RW (29),
        .PW ($bits(t_adam_side))
    ) u_adiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_valid),
        .i_rem   (rem3),
        .i_den   (r_d_den),
        .i_tail  (a_mag[33:0]),
        .i_pay   (aside_in),
        .o_valid (adiv_valid),
        .o_quot  (adiv_q),
        .o_pay   (adiv_pay)
    );

    t_adam_side         aside;
    logic [33:0]        amag;
    logic signed [35:0] adam;
    logic signed [36:0] upd_full;
    logic signed [31:0] upd;
    logic signed [32:0] nw_full;
    logic signed [31:0] nw;

    always_comb begin
        aside = t_adam_side'(adiv_pay);
        amag  = aside.a_ovf ? '1 : adiv_q;
        adam  = aside.a_neg ? -$signed({2'b00, amag}) : $signed({2'b00, amag});
        upd_full = -adam - aside.decay;
        if (upd_full > 37'sd2147483647) begin
            upd = 32'sh7FFF_FFFF;
        end else if (upd_full < -37'sd2147483648) begin
            upd = 32'sh8000_0000;
        end else begin
            upd = upd_full[31:0];
        end
        nw_full = aside.w + upd;
        if (nw_full > 33'sd2147483647) begin
            nw = 32'sh7FFF_FFFF;
        end else if (nw_full < -33'sd2147483648) begin
            nw = 32'sh8000_0000;
        end else begin
            nw = nw_full[31:0];
        end
    end

    // output register
    logic                  r_out_valid;
    adamw_pkg::t_out_item  r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= adiv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= '{out_index: aside.idx, update: upd, new_weight: nw};
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // checks
    a_pow_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pow1 <= One) && (r_pow2 <= One))
        else $error("beta power above one");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> clr_busy)
        else $error("no clearing pass after reset");

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !accept)
        else $error("word accepted during clearing pass");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mdiv_valid == vdiv_valid)
        else $error("moment divider lanes out of step");

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for adamw_parameter_update_core: streams parameter
// words through the core, predicts each update and new weight in a
// scoreboard, and compares every result word field by field.
// ----------------------------------------------------------------------------
module tb;
    import adamw_pkg::*;

    localparam int      WatchLimit      = 20000;
    localparam int      DrainCycles     = 120;
    localparam int      CfgUnknownFirst = 4;
    localparam int      CfgUnknownLast  = 15;
    localparam longint  SatMax          = 64'sd2147483647;
    localparam longint  SatMin          = -64'sd2147483648;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;

    adamw_stream_if #(.t_data(t_in_item))  in_if ();
    adamw_stream_if #(.t_data(t_out_item)) out_if ();

    adamw_parameter_update_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if.sink),
        .o_out       (out_if.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    int  n_errors;
    int  n_words_in;
    int  n_words_out;
    int  n_steps;
    bit  idle_en;
    int  quiet_cycles;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        n_errors++;
    endtask

    function automatic longint sat32(input longint x);
        if (x > SatMax) return SatMax;
        if (x < SatMin) return SatMin;
        return x;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    class adamw_scoreboard;
        int               first_mom [4096];
        int unsigned      second_mom [4096];
        longint unsigned  pow1, pow2;
        longint unsigned  beta1, beta2, lr, wd;
        t_out_item        pending_updates [$];

        function new();
            foreach (first_mom[i]) begin
                first_mom[i]  = 0;
                second_mom[i] = 0;
            end
            pow1  = OneQ131;
            pow2  = OneQ131;
            beta1 = Beta1Reset;
            beta2 = Beta2Reset;
            lr    = LrReset;
            wd    = WdReset;
        endfunction

        function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
            case (idx)
                CFG_BETA1: beta1 = d[15:0];
                CFG_BETA2: beta2 = d[15:0];
                CFG_LR:    lr    = d;
                CFG_WD:    wd    = d;
                default: ;
            endcase
        endfunction

        function void note_input(input t_in_item it);
            longint g, w, m_old, acc, m, m_hat, adam, decay, upd, nw;
            longint unsigned v_old, mag, g2, v, v_hat, root, d1, d2;
            t_out_item res;
            g = longint'(it.gradient);
            w = longint'(it.weight);
            if (it.new_step) begin
                pow1 = ((pow1 * beta1) >> 16) & 64'hFFFF_FFFF;
                pow2 = ((pow2 * beta2) >> 16) & 64'hFFFF_FFFF;
            end
            m_old = first_mom[it.param_index];
            v_old = second_mom[it.param_index];

            acc = longint'(beta1) * m_old + longint'(65536 - beta1) * g;
            m   = sat32(acc >>> 16);

            mag = (g < 0) ? longint'(-g) : g;
            g2  = (mag * mag) >> 24;
            if (g2 > 64'hFFFF_FFFF) g2 = 64'hFFFF_FFFF;
            v = (beta2 * v_old + (65536 - beta2) * g2) >> 16;
            if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;

            first_mom[it.param_index]  = int'(m);
            second_mom[it.param_index] = v[31:0];

            // a power still at one leaves the moment uncorrected
            d1 = OneQ131 - ((pow1 > OneQ131) ? OneQ131 : pow1);
            d2 = OneQ131 - ((pow2 > OneQ131) ? OneQ131 : pow2);
            m_hat = (d1 == 0) ? m : sat32((m * 64'sd2147483648) / longint'(d1));
            if (d2 == 0) begin
                v_hat = v;
            end else begin
                v_hat = (v << 31) / d2;
                if (v_hat > 64'hFFFF_FFFF) v_hat = 64'hFFFF_FFFF;
            end
            root = int_sqrt(v_hat << 24);

            adam  = (longint'(lr) * m_hat) / longint'(root + 1);
            decay = (longint'(wd) * w) / 64'sd16777216;
            upd   = sat32(-adam - decay);
            nw    = sat32(w + upd);

            res.out_index  = it.param_index;
            res.update     = upd[31:0];
            res.new_weight = nw[31:0];
            pending_updates.push_back(res);
        endfunction

        task check_result(input t_out_item got);
            t_out_item exp_w;
            if (pending_updates.size() == 0) begin
                report($sformatf("unexpected word, index %0d", got.out_index));
                return;
            end
            exp_w = pending_updates.pop_front();
            if (got.out_index !== exp_w.out_index)
                report($sformatf("out_index got %0d exp %0d", got.out_index, exp_w.out_index));
            if (got.update !== exp_w.update)
                report($sformatf("update idx %0d got %0d exp %0d",
                                 exp_w.out_index, got.update, exp_w.update));
            if (got.new_weight !== exp_w.new_weight)
                report($sformatf("new_weight idx %0d got %0d exp %0d",
                                 exp_w.out_index, got.new_weight, exp_w.new_weight));
        endtask
    endclass

    adamw_scoreboard sb;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // output side: random stall bursts, sampled on the rising edge
    int stall_left;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 3);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_result(out_if.data);
            n_words_out++;
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit) begin
            $display("watchdog expired, %0d words still awaited", sb.pending_updates.size());
            $display("adamw_parameter_update_core test failed");
            $finish;
        end
    end

    task automatic send_word(input t_in_item it);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.data  = it;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_input(it);
        n_words_in++;
        if (it.new_step) n_steps++;
        @(negedge i_clk);
    endtask

    task automatic send(input logic [11:0] idx, input logic [31:0] g,
                        input logic [31:0] w, input logic step);
        t_in_item it;
        it.param_index = idx;
        it.gradient    = g;
        it.weight      = w;
        it.new_step    = step;
        send_word(it);
    endtask

    task automatic drain();
        in_if.valid = 1'b0;
        while (sb.pending_updates.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = d;
        sb.write_reg(idx, d);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_words(input int count);
        logic [11:0] idx;
        logic [31:0] g, w;
        for (int k = 0; k < count; k++) begin
            // a small pool of indexes lets the moments build up
            idx = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
            case ($urandom_range(0, 5))
                0:       g = $urandom;
                1:       g = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                2:       g = 32'($signed(12'($urandom)));
                default: g = 32'($signed(26'($urandom)));
            endcase
            w = $urandom_range(0, 2) == 0 ? $urandom : 32'($signed(27'($urandom)));
            send(idx, g, w, $urandom_range(0, 15) == 0);
        end
    endtask

    initial begin
        sb           = new();
        n_errors     = 0;
        n_words_in   = 0;
        n_words_out  = 0;
        n_steps      = 0;
        quiet_cycles = 0;
        stall_left   = 0;
        idle_en      = 1'b1;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // no step taken yet: moments pass uncorrected
        send(12'd0,    32'h0000_0000, 32'h0000_0000, 1'b0);
        send(12'd4095, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send(12'd4095, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send(12'd1,    32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        send(12'd1,    32'h0100_0000, 32'hFF00_0000, 1'b0);
        // first step and back-to-back hits on one index
        send(12'd2,    32'h0100_0000, 32'h0100_0000, 1'b1);
        send(12'd2,    32'hFF00_0000, 32'h0100_0000, 1'b0);
        send(12'd2,    32'h0000_0001, 32'h7FFF_FFFF, 1'b0);
        send(12'd0,    32'h8000_0000, 32'h8000_0000, 1'b1);
        send(12'd4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send(12'd3,    32'h0000_0000, 32'h8000_0000, 1'b0);
        send(12'd3,    32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        send(12'd3,    32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        send(12'd2048, 32'h0000_0010, 32'hFFFF_FFF0, 1'b0);
        random_words(150);
        drain();

        // extreme settings, plus a write to an unused register code
        write_cfg(CFG_BETA1, 24'd65535);
        write_cfg(CFG_BETA2, 24'd0);
        write_cfg(CFG_LR,    24'hFF_FFFF);
        write_cfg(CFG_WD,    24'd0);
        write_cfg(CfgIdxW'($urandom_range(CfgUnknownFirst, CfgUnknownLast)), 24'($urandom));
        random_words(150);
        drain();

        write_cfg(CFG_BETA1, 24'd0);
        write_cfg(CFG_BETA2, 24'd65535);
        write_cfg(CFG_LR,    24'd0);
        write_cfg(CFG_WD,    24'hFF_FFFF);
        write_cfg(CfgIdxW'(CfgUnknownLast), 24'hFF_FFFF);
        random_words(150);
        drain();

        write_cfg(CFG_BETA1, 24'($urandom_range(0, 65535)));
        write_cfg(CFG_BETA2, 24'($urandom_range(0, 65535)));
        write_cfg(CFG_LR,    24'($urandom));
        write_cfg(CFG_WD,    24'($urandom));
        random_words(120);
        drain();

        // closing stretch at full rate on both sides
        write_cfg(CFG_BETA1, 24'(Beta1Reset));
        write_cfg(CFG_BETA2, 24'(Beta2Reset));
        write_cfg(CFG_LR,    LrReset);
        write_cfg(CFG_WD,    WdReset);
        idle_en = 1'b0;
        random_words(120);
        drain();

        $display("covered %0d words in, %0d results out, %0d optimizer steps,",
                 n_words_in, n_words_out, n_steps);
        $display("over five register settings including both extremes of every register");
        if (n_errors == 0) begin
            $display("adamw_parameter_update_core test passed");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("adamw_parameter_update_core test failed");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/adamw_pkg.sv
rtl/adamw_stream_if.sv
rtl/adamw_moment_unit.sv
rtl/adamw_div_pipe.sv
rtl/adamw_sqrt_pipe.sv
rtl/adamw_parameter_update_core.sv
verif/tb.sv
